// ----- rtl/core/fvpi_pkg.sv -----
// Shared types, widths, constants and microcode for the filtered velocity PI controller.
package fvpi_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned StateW  = 25;
  localparam int unsigned SumW    = StateW + 1;
  localparam int unsigned ProdW   = StateW + GainW;
  localparam int unsigned AccW    = ProdW + 1;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QShift  = 8;
  localparam int unsigned DriveW  = 32;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StepW   = 3;

  typedef logic [StepW-1:0] step_t;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegPropGain  = 2'd0;
  localparam logic [1:0] RegIntegGain = 2'd1;
  localparam logic [1:0] RegIntegLim  = 2'd2;

  // Filter taps: 77/256 on the new sample, 179/256 on the old value
  localparam logic [GainW-1:0]  CoefNew    = 16'd77;
  localparam logic [GainW-1:0]  CoefOld    = 16'd179;
  localparam logic [LimitW-1:0] LimitReset = 15'd3000;

  localparam step_t StepWait = 3'd0;
  localparam step_t StepLast = 3'd7;

  typedef enum logic [1:0] {
    CondNone,
    CondIn,
    CondOut
  } cond_e;

  typedef enum logic [1:0] {
    MulOldF,
    MulNewV,
    MulProp,
    MulInteg
  } mul_sel_e;

  typedef enum logic [1:0] {
    AccHold,
    AccShr,
    AccLoad,
    AccAdd
  } acc_op_e;

  typedef struct packed {
    cond_e    cond;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     f_wr;
    logic     s_wr;
    logic     out_wr;
    logic     jmp;
    step_t    target;
  } ctrl_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    w.cond    = CondNone;
    w.mul_sel = MulOldF;
    w.acc_op  = AccHold;
    w.f_wr    = 1'b0;
    w.s_wr    = 1'b0;
    w.out_wr  = 1'b0;
    w.jmp     = 1'b0;
    w.target  = StepWait;
    unique case (step)
      3'd0: begin
        // wait for a sample, keep 179*f in flight
        w.cond    = CondIn;
        w.mul_sel = MulOldF;
      end
      3'd1: begin
        w.mul_sel = MulNewV;
        w.acc_op  = AccShr;
      end
      3'd2: begin
        w.acc_op = AccAdd;
      end
      3'd3: begin
        w.f_wr = 1'b1;
      end
      3'd4: begin
        w.s_wr    = 1'b1;
        w.mul_sel = MulProp;
      end
      3'd5: begin
        w.mul_sel = MulInteg;
        w.acc_op  = AccLoad;
      end
      3'd6: begin
        w.acc_op = AccAdd;
      end
      3'd7: begin
        w.cond   = CondOut;
        w.out_wr = 1'b1;
        w.jmp    = 1'b1;
        w.target = StepWait;
      end
      default: begin
        w.jmp    = 1'b1;
        w.target = StepWait;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/fvpi_datapath.sv -----
// Datapath: shared multiplier, accumulator, filter and integral state, output scaling.
module fvpi_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fvpi_pkg::ctrl_t                  ctrl_i,
  input  logic                             load_v_i,
  input  logic signed [fvpi_pkg::SampleW-1:0] speed_sample_i,
  input  logic signed [fvpi_pkg::GainW-1:0]   prop_gain_i,
  input  logic signed [fvpi_pkg::GainW-1:0]   integ_gain_i,
  input  logic        [fvpi_pkg::LimitW-1:0]  integ_limit_i,
  output logic signed [fvpi_pkg::DriveW-1:0]  drive_o
);
  import fvpi_pkg::*;

  logic signed [SampleW-1:0] v_q;
  logic signed [StateW-1:0]  f_q;
  logic signed [StateW-1:0]  s_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [ProdW-1:0]   prod_d;
  logic signed [AccW-1:0]    acc_q;
  logic signed [AccW-1:0]    acc_d;
  logic signed [AccW-1:0]    acc_adj;
  logic signed [StateW-1:0]  mul_a;
  logic signed [GainW-1:0]   mul_b;
  logic signed [SumW-1:0]    sum;
  logic signed [SumW-1:0]    lim;
  logic signed [SumW-1:0]    s_d;
  logic signed [AccW-FracW-1:0] quo;

  always_comb begin
    unique case (ctrl_i.mul_sel)
      MulOldF: begin
        mul_a = f_q;
        mul_b = CoefOld;
      end
      MulNewV: begin
        mul_a = StateW'(v_q);
        mul_b = CoefNew;
      end
      MulProp: begin
        mul_a = f_q;
        mul_b = prop_gain_i;
      end
      MulInteg: begin
        mul_a = s_q;
        mul_b = integ_gain_i;
      end
      default: begin
        mul_a = f_q;
        mul_b = CoefOld;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    unique case (ctrl_i.acc_op)
      AccHold: acc_d = acc_q;
      AccShr:  acc_d = AccW'(prod_q >>> QShift);
      AccLoad: acc_d = AccW'(prod_q);
      AccAdd:  acc_d = acc_q + AccW'(prod_q);
      default: acc_d = acc_q;
    endcase
  end

  // Clamp the integral to +/- limit in Q.8
  assign sum = SumW'(s_q) + SumW'(f_q);
  assign lim = $signed({{(SumW-LimitW-QShift){1'b0}}, integ_limit_i, {QShift{1'b0}}});

  always_comb begin
    priority if (sum > lim) begin
      s_d = lim;
    end else if (sum < -lim) begin
      s_d = -lim;
    end else begin
      s_d = sum;
    end
  end

  // Truncate toward zero: bias negative values before the shift.
  // The quotient spans 26 bits, so it always lies inside the 32-bit range.
  assign acc_adj = acc_q[AccW-1] ? acc_q + AccW'((64'd1 << FracW) - 64'd1) : acc_q;
  assign quo     = acc_adj[AccW-1:FracW];
  assign drive_o = DriveW'(quo);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (load_v_i) begin
      v_q <= speed_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
      s_q <= '0;
    end else begin
      if (ctrl_i.f_wr) begin
        f_q <= acc_q[StateW-1:0];
      end
      if (ctrl_i.s_wr) begin
        s_q <= s_d[StateW-1:0];
      end
    end
  end

endmodule

// ----- rtl/core/filtered_velocity_pi_controller.sv -----
// Filtered velocity PI controller: sequencer, configuration registers, output register.
//
// Usage: one signed speed sample enters on the in channel (valid/ready) per beat;
// each sample yields exactly one drive value beat on the out channel.
// The sample is low-pass filtered (77/256 new, 179/256 old), added to a
// clamped integral, and drive = (prop_gain*filtered + integ_gain*integral)/65536,
// truncated toward zero.
// An 8-step microprogram runs every sample through one shared 25x16 multiplier;
// the result register loads at the last step, together with the valid flag, and
// the drive beat is offered from it; a new sample is taken only once the program
// is back at its wait step.
// The result sits in an output register, so the next sample is accepted while
// the previous result waits; if that result is still held at the last step the
// program stops there until the receiver takes it.
// Reset clears the filter and integral state, sets both gains to 0 and the
// integral limit to 3000. Gains and limit are written over the APB port at
// byte addresses 0, 4 and 8, by the user only while idle; the block does not enforce it.
module filtered_velocity_pi_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [fvpi_pkg::SampleW-1:0]  speed_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fvpi_pkg::DriveW-1:0]   drive_value_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [fvpi_pkg::AddrW-1:0]    paddr,
  input  logic        [fvpi_pkg::DataW-1:0]    pwdata,
  output logic        [fvpi_pkg::DataW-1:0]    prdata,
  output logic                                 pready
);
  import fvpi_pkg::*;

  step_t                     step_q;
  step_t                     step_d;
  ctrl_t                     uw;
  ctrl_t                     dp_ctrl;
  logic                      stall;
  logic                      in_acc;
  logic                      cfg_wr;
  logic [1:0]                reg_idx;
  logic signed [GainW-1:0]   prop_gain_q;
  logic signed [GainW-1:0]   integ_gain_q;
  logic [LimitW-1:0]         integ_limit_q;
  logic                      out_valid_q;
  logic signed [DriveW-1:0]  drive_q;
  logic signed [DriveW-1:0]  drive_d;

  assign uw         = ucode(step_q);
  assign in_ready_o = (uw.cond == CondIn);
  assign in_acc     = in_valid_i & in_ready_o;

  assign stall = ((uw.cond == CondIn) && !in_valid_i) ||
                 ((uw.cond == CondOut) && out_valid_q && !out_ready_i);

  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (uw.jmp) begin
      step_d = uw.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // Drop all writes of a stalled step
  always_comb begin
    dp_ctrl        = uw;
    dp_ctrl.f_wr   = uw.f_wr & ~stall;
    dp_ctrl.s_wr   = uw.s_wr & ~stall;
    dp_ctrl.out_wr = uw.out_wr & ~stall;
    if (stall) begin
      dp_ctrl.acc_op = AccHold;
    end
  end

  fvpi_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (dp_ctrl),
    .load_v_i       (in_acc),
    .speed_sample_i (speed_sample_i),
    .prop_gain_i    (prop_gain_q),
    .integ_gain_i   (integ_gain_q),
    .integ_limit_i  (integ_limit_q),
    .drive_o        (drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepWait;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (dp_ctrl.out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_ctrl.out_wr) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      integ_limit_q <= LimitReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegPropGain:  prop_gain_q   <= pwdata[GainW-1:0];
        RegIntegGain: integ_gain_q  <= pwdata[GainW-1:0];
        RegIntegLim:  integ_limit_q <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPropGain:  prdata = DataW'($unsigned(prop_gain_q));
      RegIntegGain: prdata = DataW'($unsigned(integ_gain_q));
      RegIntegLim:  prdata = DataW'(integ_limit_q);
      default:      prdata = '0;
    endcase
  end

  // Samples enter only at the wait step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> step_q == StepWait)
    else $error("sample accepted outside the wait step");

  // Middle steps never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != StepWait && step_q != StepLast) |=> step_q == $past(step_q) + 1'b1)
    else $error("microprogram did not advance");

  // A new result appears only from the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == StepLast)
    else $error("result valid raised outside the last step");

  // A held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !dp_ctrl.out_wr)
    else $error("pending result overwritten");

endmodule

// ----- sim/tb_filtered_velocity_pi_controller.sv -----
// Testbench for the filtered velocity PI controller: APB setup, sample beats, drive checks.
`timescale 1ns / 1ps

module tb_filtered_velocity_pi_controller;
  import fvpi_pkg::*;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam longint FiltNewTap = 77;
  localparam longint FiltOldTap = 179;
  localparam longint DriveMax = 2147483647;
  localparam longint DriveMin = -DriveMax - 1;
  localparam int PhaseCnt = 8;
  localparam int PhaseLen = 100;
  localparam int SettleCycles = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SampleW-1:0] speed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DriveW-1:0] drive_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  // Controller model state, Q.8
  longint filt_q8;
  longint integ_q8;
  longint kp_gain;
  longint ki_gain;
  longint integ_lim;

  logic signed [DriveW-1:0] drive_expected_q[$];
  logic signed [DriveW-1:0] drive_exp;
  int mismatch_cnt = 0;
  bit in_pause_en = 1'b1;
  bit out_pause_en = 1'b1;

  filtered_velocity_pi_controller dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .speed_sample_i (speed),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .drive_value_o  (drive_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [DriveW-1:0] predict_drive(input logic signed [SampleW-1:0] s);
    longint v;
    longint acc;
    v = s;
    filt_q8 = FiltNewTap * v + ((FiltOldTap * filt_q8) >>> 8);
    integ_q8 = integ_q8 + filt_q8;
    if (integ_q8 > integ_lim * 256) integ_q8 = integ_lim * 256;
    if (integ_q8 < -integ_lim * 256) integ_q8 = -integ_lim * 256;
    acc = kp_gain * filt_q8 + ki_gain * integ_q8;
    // signed division truncates toward zero
    acc = acc / 65536;
    if (acc > DriveMax) acc = DriveMax;
    if (acc < DriveMin) acc = DriveMin;
    return acc[DriveW-1:0];
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [DataW-1:0] data);
    case (idx)
      RegPropGain: begin
        kp_gain = $signed(data[GainW-1:0]);
      end
      RegIntegGain: begin
        ki_gain = $signed(data[GainW-1:0]);
      end
      RegIntegLim: begin
        integ_lim = data[LimitW-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx, output logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    logic [DataW-1:0] rd;
    read_reg(RegPropGain, rd);
    if (rd[GainW-1:0] !== kp_gain[GainW-1:0]) begin
      $error("prop_gain: expected %0d, actual %0d", kp_gain, $signed(rd[GainW-1:0]));
      mismatch_cnt++;
    end
    read_reg(RegIntegGain, rd);
    if (rd[GainW-1:0] !== ki_gain[GainW-1:0]) begin
      $error("integ_gain: expected %0d, actual %0d", ki_gain, $signed(rd[GainW-1:0]));
      mismatch_cnt++;
    end
    read_reg(RegIntegLim, rd);
    if (rd[LimitW-1:0] !== integ_lim[LimitW-1:0]) begin
      $error("integ_limit: expected %0d, actual %0d", integ_lim, rd[LimitW-1:0]);
      mismatch_cnt++;
    end
  endtask

  // Send one sample beat; valid stays high across back-to-back beats
  task automatic send_speed(input logic signed [SampleW-1:0] s);
    int gap;
    gap = in_pause_en ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    speed <= s;
    do @(posedge clk); while (!in_ready);
    drive_expected_q.push_back(predict_drive(s));
  endtask

  // Drop valid and drain all pending drive values
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (drive_expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_reset_values();
    check_regs();
    send_speed(16'sh7FFF);
    send_speed(-16'sh8000);
    send_speed(16'sh0000);
  endtask

  task automatic test_gain_extremes();
    wait_idle();
    write_reg(RegPropGain, 32'h0000_7FFF);
    write_reg(RegIntegGain, 32'h0000_7FFF);
    write_reg(RegIntegLim, 32'h0000_7FFF);
    check_regs();
    // drive the integral into its positive clamp
    repeat (6) send_speed(16'sh7FFF);
    repeat (4) send_speed(-16'sh8000);
    wait_idle();
    write_reg(RegPropGain, 32'hA5A5_8000);
    write_reg(RegIntegGain, 32'h5A5A_8000);
    check_regs();
    send_speed(16'sh7FFF);
    send_speed(-16'sh0001);
    send_speed(16'sh0001);
  endtask

  task automatic test_spare_addr();
    wait_idle();
    write_reg(RegSpare, 32'hFFFF_FFFF);
    check_regs();
    send_speed(16'sh1234);
  endtask

  task automatic test_zero_limit();
    wait_idle();
    // low 15 bits clear, upper bits set
    write_reg(RegIntegLim, 32'hFFFF_8000);
    write_reg(RegIntegGain, 32'h0000_7FFF);
    check_regs();
    send_speed(16'sh7FFF);
    send_speed(16'sh7FFF);
    send_speed(-16'sh8000);
    send_speed(16'sh0100);
  endtask

  function automatic logic [DataW-1:0] draw_gain();
    logic [DataW-1:0] data;
    data = $urandom;
    case ($urandom_range(0, 3))
      0: data[GainW-1:0] = 16'h7FFF;
      1: data[GainW-1:0] = 16'h8000;
      default: begin
      end
    endcase
    return data;
  endfunction

  function automatic logic [DataW-1:0] draw_limit();
    logic [DataW-1:0] data;
    data = $urandom;
    case ($urandom_range(0, 4))
      0: data[LimitW-1:0] = '0;
      1: data[LimitW-1:0] = '1;
      2: data[LimitW-1:0] = LimitW'($urandom_range(1, 5000));
      default: begin
      end
    endcase
    return data;
  endfunction

  task automatic test_random_phases();
    logic signed [SampleW-1:0] s;
    for (int ph = 0; ph < PhaseCnt; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          in_pause_en = 1'b0;
          out_pause_en = 1'b0;
        end
        1: begin
          in_pause_en = 1'b1;
          out_pause_en = 1'b1;
        end
        2: begin
          in_pause_en = 1'b1;
          out_pause_en = 1'b0;
        end
        3: begin
          in_pause_en = 1'b0;
          out_pause_en = 1'b1;
        end
        default: begin
          in_pause_en = 1'($urandom_range(0, 1));
          out_pause_en = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(RegPropGain, draw_gain());
      write_reg(RegIntegGain, draw_gain());
      write_reg(RegIntegLim, draw_limit());
      check_regs();
      s = '0;
      for (int n = 0; n < PhaseLen; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: s = SampleW'($urandom);
          4, 5, 6: s = SampleW'($signed($urandom_range(0, 600)) - 300);
          // hold the sample to walk the integral into its clamp
          7, 8: begin
          end
          default: s = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
        endcase
        send_speed(s);
      end
    end
  endtask

  // Receiver: when out_pause_en is set, stall a random number of cycles before each drive beat
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = out_pause_en ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_expected_q.size() == 0) begin
        $error("drive_value: expected none, actual %0d", drive_value);
        mismatch_cnt++;
      end else begin
        drive_exp = drive_expected_q.pop_front();
        if (drive_value !== drive_exp) begin
          $error("drive_value: expected %0d, actual %0d", drive_exp, drive_value);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    filt_q8 = 0;
    integ_q8 = 0;
    kp_gain = 0;
    ki_gain = 0;
    integ_lim = LimitReset;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_gain_extremes();
    test_spare_addr();
    test_zero_limit();
    test_random_phases();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
